// ----- rtl/core/splat_covariance_from_scale_quat_defines.svh -----
// assertion helpers shared by the covariance block
`ifndef SPLAT_COVARIANCE_FROM_SCALE_QUAT_DEFINES_SVH
`define SPLAT_COVARIANCE_FROM_SCALE_QUAT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SCQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// invariant that holds at every edge out of reset
`define SCQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

// ----- rtl/core/scq_pkg.sv -----
`default_nettype none
package scq_pkg;

  // fraction bits of the rotation entries
  localparam int unsigned RFrac = 28;
  // quotient bits of the normalizing divide
  localparam int unsigned QBits = 29;
  // register stages inside one divider lane
  localparam int unsigned DivLat = QBits + 1;
  localparam int unsigned TShift = 16;
  localparam int unsigned CShift = 28;

  typedef logic signed [33:0] num_t;
  typedef logic [32:0] norm_t;
  typedef logic signed [29:0] rot_t;
  typedef logic signed [30:0] tmat_t;

  // shift right by k, round to nearest, ties away from zero
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned k);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? 64'(-v) : 64'(v);
    m = (mag + (64'd1 << (k - 1))) >> k;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  // clamp to the signed 32 bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/scq_div.sv -----
`default_nettype none
// pipelined restoring divider: round(|num| * 2^28 / n) with the sign of num, one quotient bit per stage
module scq_div (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire scq_pkg::num_t  num_i,
  input  wire scq_pkg::norm_t n_i,
  output scq_pkg::rot_t       rot_o
);

  localparam int unsigned Lat = scq_pkg::DivLat;
  localparam int unsigned QB = scq_pkg::QBits;

  logic [32:0]   rem_q [Lat];
  logic [QB-1:0] low_q [Lat];
  logic [QB-1:0] quo_q [Lat];
  scq_pkg::norm_t n_q  [Lat];
  logic          neg_q [Lat];

  logic [33:0] mag;
  logic [60:0] dvd;

  // dividend with half the divisor added for rounding
  always_comb begin
    mag = num_i[33] ? 34'(-num_i) : 34'(num_i);
    dvd = {mag[32:0], scq_pkg::RFrac'(0)} + 61'(n_i >> 1);
  end

  // first stage loads the high dividend bits, below the divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {1'b0, dvd[60:QB]};
      low_q[0] <= dvd[QB-1:0];
      quo_q[0] <= '0;
      n_q[0]   <= n_i;
      neg_q[0] <= num_i[33];
    end
  end

  // one compare and subtract per stage
  for (genvar k = 1; k < Lat; k++) begin : g_stage
    logic [33:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem_q[k-1], low_q[k-1][QB-k]};
      ge    = trial >= {1'b0, n_q[k-1]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? 33'(trial - {1'b0, n_q[k-1]}) : trial[32:0];
        low_q[k] <= low_q[k-1];
        quo_q[k] <= quo_q[k-1] | (QB'(ge) << (QB - k));
        n_q[k]   <= n_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // apply the sign of the numerator
  assign rot_o = neg_q[Lat-1] ? -$signed({1'b0, quo_q[Lat-1]})
                              : $signed({1'b0, quo_q[Lat-1]});

endmodule
`default_nettype wire

// ----- rtl/core/splat_covariance_from_scale_quat.sv -----
// path: an accepted request passes stages a and b, the divider lanes and stages c to h to the master side
// throughput: one request per cycle while the output is not stalled; the 30-stage divider lanes set the depth
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// reset: asynchronous active low, clears all valid bits; data registers are not reset
`default_nettype none
`include "splat_covariance_from_scale_quat_defines.svh"
module splat_covariance_from_scale_quat (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // scale_x, scale_y, scale_z, quat_x, quat_y, quat_z, quat_w
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz
  output logic [191:0]      m_axis_tdata,
  // zero_quat
  output logic              m_axis_tuser
);

  localparam int unsigned Lat = scq_pkg::DivLat;

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // stage a: quaternion pair products
  logic        vld_a_q;
  logic [15:0] scl_a_q [3];
  logic signed [31:0] xx_q, yy_q, zz_q, ww_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  logic signed [15:0] qx, qy, qz, qw;
  assign qx = $signed(s_axis_tdata[63:48]);
  assign qy = $signed(s_axis_tdata[79:64]);
  assign qz = $signed(s_axis_tdata[95:80]);
  assign qw = $signed(s_axis_tdata[111:96]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (adv) begin
      vld_a_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      scl_a_q[0] <= s_axis_tdata[15:0];
      scl_a_q[1] <= s_axis_tdata[31:16];
      scl_a_q[2] <= s_axis_tdata[47:32];
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      zz_q <= qz * qz;
      ww_q <= qw * qw;
      xy_q <= qx * qy;
      xz_q <= qx * qz;
      yz_q <= qy * qz;
      xw_q <= qx * qw;
      yw_q <= qy * qw;
      zw_q <= qz * qw;
    end
  end

  // stage b: squared norm and rotation numerators
  logic           vld_b_q, zq_b_q;
  logic [15:0]    scl_b_q [3];
  scq_pkg::norm_t n_b_q;
  scq_pkg::num_t  num_b_q [9];
  logic signed [35:0] n_s;

  always_comb begin
    n_s = 36'(xx_q) + 36'(yy_q) + 36'(zz_q) + 36'(ww_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (adv) begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      scl_b_q    <= scl_a_q;
      zq_b_q     <= (n_s == '0);
      n_b_q      <= n_s[32:0];
      num_b_q[0] <= 34'(n_s - 36'sd2 * (36'(yy_q) + 36'(zz_q)));
      num_b_q[1] <= 34'(36'sd2 * (36'(xy_q) - 36'(zw_q)));
      num_b_q[2] <= 34'(36'sd2 * (36'(xz_q) + 36'(yw_q)));
      num_b_q[3] <= 34'(36'sd2 * (36'(xy_q) + 36'(zw_q)));
      num_b_q[4] <= 34'(n_s - 36'sd2 * (36'(xx_q) + 36'(zz_q)));
      num_b_q[5] <= 34'(36'sd2 * (36'(yz_q) - 36'(xw_q)));
      num_b_q[6] <= 34'(36'sd2 * (36'(xz_q) - 36'(yw_q)));
      num_b_q[7] <= 34'(36'sd2 * (36'(yz_q) + 36'(xw_q)));
      num_b_q[8] <= 34'(n_s - 36'sd2 * (36'(xx_q) + 36'(yy_q)));
    end
  end

  // divider lanes, one per rotation entry
  scq_pkg::rot_t rot_div [9];
  for (genvar e = 0; e < 9; e++) begin : g_div
    scq_div u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (num_b_q[e]),
      .n_i    (n_b_q),
      .rot_o  (rot_div[e])
    );
  end

  // side data travels next to the divider lanes
  logic        vld_dl_q [Lat];
  logic        zq_dl_q  [Lat];
  logic [15:0] scl_dl_q [Lat][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) vld_dl_q[i] <= 1'b0;
    end else if (adv) begin
      vld_dl_q[0] <= vld_b_q;
      for (int i = 1; i < Lat; i++) vld_dl_q[i] <= vld_dl_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zq_dl_q[0]  <= zq_b_q;
      scl_dl_q[0] <= scl_b_q;
      for (int i = 1; i < Lat; i++) begin
        zq_dl_q[i]  <= zq_dl_q[i-1];
        scl_dl_q[i] <= scl_dl_q[i-1];
      end
    end
  end

  // stage c: rotation, identity for a zero quaternion
  logic          vld_c_q, zq_c_q;
  logic [15:0]   scl_c_q [3];
  scq_pkg::rot_t rot_c_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else if (adv) begin
      vld_c_q <= vld_dl_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zq_c_q  <= zq_dl_q[Lat-1];
      scl_c_q <= scl_dl_q[Lat-1];
      for (int e = 0; e < 9; e++) begin
        if (zq_dl_q[Lat-1]) begin
          rot_c_q[e] <= (e % 4 == 0) ? 30'sd1 <<< scq_pkg::RFrac : '0;
        end else begin
          rot_c_q[e] <= rot_div[e];
        end
      end
    end
  end

  // stage d: rotation times scale
  logic vld_d_q, zq_d_q;
  logic signed [46:0] rs_d_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else if (adv) begin
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zq_d_q <= zq_c_q;
      for (int e = 0; e < 9; e++) begin
        rs_d_q[e] <= 47'(rot_c_q[e]) * 47'($signed({1'b0, scl_c_q[e % 3]}));
      end
    end
  end

  // stage e: round to the t matrix
  logic vld_e_q, zq_e_q;
  scq_pkg::tmat_t t_e_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
    end else if (adv) begin
      vld_e_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zq_e_q <= zq_d_q;
      for (int e = 0; e < 9; e++) begin
        t_e_q[e] <= 31'(scq_pkg::round_shift(64'(rs_d_q[e]), scq_pkg::TShift));
      end
    end
  end

  // stage f: row products for the six upper entries
  localparam int RowI [6] = '{0, 0, 0, 1, 1, 2};
  localparam int ColI [6] = '{0, 1, 2, 1, 2, 2};
  logic vld_f_q, zq_f_q;
  logic signed [61:0] pr_f_q [6][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= 1'b0;
    end else if (adv) begin
      vld_f_q <= vld_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zq_f_q <= zq_e_q;
      for (int e = 0; e < 6; e++) begin
        for (int k = 0; k < 3; k++) begin
          pr_f_q[e][k] <= 62'(t_e_q[RowI[e]*3 + k]) * 62'(t_e_q[ColI[e]*3 + k]);
        end
      end
    end
  end

  // stage g: sums
  logic vld_g_q, zq_g_q;
  logic signed [63:0] acc_g_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_g_q <= 1'b0;
    end else if (adv) begin
      vld_g_q <= vld_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zq_g_q <= zq_f_q;
      for (int e = 0; e < 6; e++) begin
        acc_g_q[e] <= 64'(pr_f_q[e][0]) + 64'(pr_f_q[e][1]) + 64'(pr_f_q[e][2]);
      end
    end
  end

  // stage h: round, saturate, output register
  logic        vld_h_q, zq_h_q;
  logic [31:0] cov_h_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_h_q <= 1'b0;
    end else if (adv) begin
      vld_h_q <= vld_g_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zq_h_q <= zq_g_q;
      for (int e = 0; e < 6; e++) begin
        cov_h_q[e] <= scq_pkg::sat32(scq_pkg::round_shift(acc_g_q[e], scq_pkg::CShift));
      end
    end
  end

  assign m_axis_tvalid = vld_h_q;
  assign m_axis_tuser  = zq_h_q;
  assign m_axis_tdata  = {cov_h_q[5], cov_h_q[4], cov_h_q[3],
                          cov_h_q[2], cov_h_q[1], cov_h_q[0]};

  // identity rotation leaves no off-diagonal terms
  `SCQ_ASSERT_IMP(a_zero_quat_diag, m_axis_tvalid && m_axis_tuser,
                  m_axis_tdata[63:32] == '0 && m_axis_tdata[95:64] == '0 &&
                  m_axis_tdata[159:128] == '0, "off-diagonal nonzero for zero quaternion")
  // diagonal entries are sums of squares
  `SCQ_ASSERT_ALWAYS(a_diag_nonneg, !m_axis_tvalid ||
                     (!m_axis_tdata[31] && !m_axis_tdata[127] && !m_axis_tdata[191]),
                     "negative diagonal covariance")
  // a held result stops the input side
  `SCQ_ASSERT_IMP(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready,
                  !s_axis_tready, "input taken while output stalled")

endmodule
`default_nettype wire
